FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands for the bit packer, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising clock edge
`define HCBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that a condition implies another one in the next cycle
`define HCBP_ASSERT_NEXT(label, pre, post, msg) \
    `HCBP_ASSERT(label, (pre) |=> (post), msg)

`endif

FILE: src/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared constants, operation codes and types of the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int BYTE_W           = 8;
    localparam int SYM_W            = 8;
    localparam int VAL_W            = 32;
    localparam int LEN_IN_W         = 6;
    localparam int OP_W             = 2;
    localparam int PEND_W           = 7;
    localparam int CNT_W            = 3;
    localparam int TBL_DEPTH        = 256;
    localparam int TDATA_W          = 48;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic vld;
        logic adv;
    } t_s1_st;

endpackage

FILE: src/hcbp_table.sv
// ----------------------------------------------------------------------------
// hcbp_table
// Code table: code and length memories with registered read and
// per-entry valid bits so that unloaded entries read as zero length.
// ----------------------------------------------------------------------------
module hcbp_table #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN,
    parameter int CODE_W       = hcbp_pkg::VAL_W,
    parameter int LEN_W        = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic                          i_rd_en,
    input  logic [hcbp_pkg::SYM_W-1:0]    i_addr,
    input  logic [hcbp_pkg::VAL_W-1:0]    i_code_raw,
    input  logic [hcbp_pkg::LEN_IN_W-1:0] i_len_raw,
    output logic [CODE_W-1:0]             o_code,
    output logic [LEN_W-1:0]              o_len
);

    localparam logic [CODE_W-1:0] ONES = '1;

    logic [CODE_W-1:0]             r_code_mem [hcbp_pkg::TBL_DEPTH];
    logic [LEN_W-1:0]              r_len_mem  [hcbp_pkg::TBL_DEPTH];
    logic [hcbp_pkg::TBL_DEPTH-1:0] r_vld;
    logic [CODE_W-1:0]             r_rd_code;
    logic [LEN_W-1:0]              r_rd_len;
    logic                          r_rd_hit;
    logic [LEN_W-1:0]              len_sat;
    logic [CODE_W-1:0]             code_wr;

    always_comb begin
        if (int'(i_len_raw) > MAX_CODE_LEN) begin
            len_sat = LEN_W'(MAX_CODE_LEN);
        end else begin
            len_sat = i_len_raw[LEN_W-1:0];
        end
        code_wr = i_code_raw[CODE_W-1:0] & ~(ONES << len_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_code_mem[i_addr] <= code_wr;
            r_len_mem[i_addr]  <= len_sat;
        end
        if (i_rd_en) begin
            r_rd_code <= r_code_mem[i_addr];
            r_rd_len  <= r_len_mem[i_addr];
            r_rd_hit  <= r_vld[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_addr] <= 1'b1;
        end
    end

    assign o_code = r_rd_hit ? r_rd_code : '0;
    assign o_len  = r_rd_hit ? r_rd_len  : '0;

endmodule

FILE: src/hcbp_encode.sv
// ----------------------------------------------------------------------------
// hcbp_encode
// Read-modify stage: merges the table entry with the pending bits or, on a
// flush, pads them; updates the pending state and feeds the byte emitter.
// ----------------------------------------------------------------------------
module hcbp_encode #(
    parameter int CODE_W = hcbp_pkg::VAL_W,
    parameter int LEN_W  = 6,
    parameter int ACC_W  = 39,
    parameter int POS_W  = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [hcbp_pkg::OP_W-1:0] i_op,
    input  logic [CODE_W-1:0]         i_code,
    input  logic [LEN_W-1:0]          i_len,
    input  logic                      i_em_free,
    output hcbp_pkg::t_s1_st          o_st,
    output logic                      o_em_load,
    output logic [ACC_W-1:0]          o_acc,
    output logic [POS_W-1:0]          o_pos
);

    localparam logic [hcbp_pkg::PEND_W-1:0] PEND_ONES = '1;

    logic                        r_s1_vld;
    logic [hcbp_pkg::OP_W-1:0]   r_s1_op;
    logic [hcbp_pkg::PEND_W-1:0] r_pend_bits;
    logic [hcbp_pkg::CNT_W-1:0]  r_pend_cnt;
    logic                        r_empty;
    logic [hcbp_pkg::PEND_W-1:0] n_pend_bits;
    logic [hcbp_pkg::CNT_W-1:0]  n_pend_cnt;
    logic                        n_empty;
    logic                        s1_adv;
    logic [ACC_W-1:0]            acc_enc;
    logic [POS_W-1:0]            tot_enc;
    logic [hcbp_pkg::BYTE_W-1:0] fl_byte;
    logic                        fl_emit;

    assign s1_adv = r_s1_vld && i_em_free;

    always_comb begin
        acc_enc = (ACC_W'(r_pend_bits) << i_len) | ACC_W'(i_code);
        tot_enc = POS_W'(r_pend_cnt) + POS_W'(i_len);
        fl_byte = r_empty ? '0 : hcbp_pkg::BYTE_W'({1'b0, r_pend_bits}
                  << (4'd8 - {1'b0, r_pend_cnt}));
        fl_emit = r_empty || (r_pend_cnt != '0);

        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_empty     = r_empty;
        o_acc       = acc_enc;
        o_pos       = '0;
        case (r_s1_op)
            hcbp_pkg::OP_ENCODE: begin
                if (i_len != '0) begin
                    n_pend_bits = hcbp_pkg::PEND_W'(acc_enc)
                                  & ~(PEND_ONES << tot_enc[hcbp_pkg::CNT_W-1:0]);
                    n_pend_cnt  = tot_enc[hcbp_pkg::CNT_W-1:0];
                    n_empty     = 1'b0;
                    o_pos       = tot_enc;
                end
            end
            hcbp_pkg::OP_FLUSH: begin
                n_pend_bits = '0;
                n_pend_cnt  = '0;
                n_empty     = 1'b1;
                o_acc       = ACC_W'(fl_byte);
                o_pos       = fl_emit ? POS_W'(hcbp_pkg::BYTE_W) : '0;
            end
            default: begin
                o_pos = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_empty     <= 1'b1;
        end else begin
            if (i_accept) begin
                r_s1_vld <= (i_op == hcbp_pkg::OP_ENCODE) || (i_op == hcbp_pkg::OP_FLUSH);
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_pend_bits <= n_pend_bits;
                r_pend_cnt  <= n_pend_cnt;
                r_empty     <= n_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_op <= i_op;
        end
    end

    assign o_em_load = s1_adv;
    assign o_st.vld  = r_s1_vld;
    assign o_st.adv  = s1_adv;

endmodule

FILE: src/hcbp_emit.sv
// ----------------------------------------------------------------------------
// hcbp_emit
// Byte emitter: holds the completed bits of one item and sends them out
// one byte per cycle while the receiver is ready, earliest bits first.
// ----------------------------------------------------------------------------
module hcbp_emit #(
    parameter int ACC_W = 39,
    parameter int POS_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [ACC_W-1:0]            i_acc,
    input  logic [POS_W-1:0]            i_pos,
    output logic                        o_free,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [hcbp_pkg::BYTE_W-1:0] o_tdata,
    output logic                        o_tlast
);

    logic [ACC_W-1:0] r_acc;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] sh;
    logic             take;

    assign sh       = r_pos - POS_W'(hcbp_pkg::BYTE_W);
    assign o_tvalid = r_pos >= POS_W'(hcbp_pkg::BYTE_W);
    assign o_tlast  = sh < POS_W'(hcbp_pkg::BYTE_W);
    assign o_tdata  = hcbp_pkg::BYTE_W'(r_acc >> sh);
    assign take     = o_tvalid && i_tready;
    assign o_free   = !o_tvalid || (i_tready && o_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_load) begin
            r_pos <= i_pos;
        end else if (take) begin
            r_pos <= sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= i_acc;
        end
    end

endmodule

FILE: src/huffman_code_bit_packer.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Variable-length code table plus bit packer for a byte stream.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tuser carries the operation (load entry, encode,
// flush); s_axis_tdata carries symbol, code bits and code length.
// Output stream: m_axis_tdata is one packed byte, m_axis_tlast marks the
// final byte caused by one input item.
// An item's table entry is read at the accepting edge; the merge with the
// pending bits then loads the byte emitter, whose register presents the
// first byte. A busy emitter holds the item in the merge stage.
// Throughput: one item per cycle while each item yields at most one byte
// and the receiver is ready; an item yielding more bytes holds the input
// until the byte emitter is on its last byte.
// Loads write the table in the cycle they are accepted; an encode of the
// same symbol in the next cycle already sees the new entry.
// Reset clears the table (all lengths zero), the pending bits and marks the
// stream empty. A stalled receiver holds the current byte; the input keeps
// accepting until the merge stage holds an item it cannot pass on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] symbol, [39:8] code_value, [45:40] code_length, [47:46] zero
    input  logic [hcbp_pkg::TDATA_W-1:0]   s_axis_tdata,
    // [1:0] op
    input  logic [hcbp_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] out_byte
    output logic [hcbp_pkg::BYTE_W-1:0]    m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int CODE_W = (MAX_CODE_LEN < hcbp_pkg::VAL_W) ? MAX_CODE_LEN : hcbp_pkg::VAL_W;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ACC_W  = hcbp_pkg::PEND_W + MAX_CODE_LEN;
    localparam int POS_W  = $clog2(ACC_W + 1);

    logic                  accept;
    logic [CODE_W-1:0]     tbl_code;
    logic [LEN_W-1:0]      tbl_len;
    hcbp_pkg::t_s1_st      s1_st;
    logic                  em_free;
    logic                  em_load;
    logic [ACC_W-1:0]      em_acc;
    logic [POS_W-1:0]      em_pos;

    assign s_axis_tready = !s1_st.vld || em_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    hcbp_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .CODE_W       (CODE_W),
        .LEN_W        (LEN_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (accept && (s_axis_tuser == hcbp_pkg::OP_LOAD)),
        .i_rd_en    (accept && (s_axis_tuser == hcbp_pkg::OP_ENCODE)),
        .i_addr     (s_axis_tdata[7:0]),
        .i_code_raw (s_axis_tdata[39:8]),
        .i_len_raw  (s_axis_tdata[45:40]),
        .o_code     (tbl_code),
        .o_len      (tbl_len)
    );

    hcbp_encode #(
        .CODE_W (CODE_W),
        .LEN_W  (LEN_W),
        .ACC_W  (ACC_W),
        .POS_W  (POS_W)
    ) u_encode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (s_axis_tuser),
        .i_code    (tbl_code),
        .i_len     (tbl_len),
        .i_em_free (em_free),
        .o_st      (s1_st),
        .o_em_load (em_load),
        .o_acc     (em_acc),
        .o_pos     (em_pos)
    );

    hcbp_emit #(
        .ACC_W (ACC_W),
        .POS_W (POS_W)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (em_load),
        .i_acc    (em_acc),
        .i_pos    (em_pos),
        .o_free   (em_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    `HCBP_ASSERT_NEXT(a_s1_hold, s1_st.vld && !em_free, s1_st.vld, "stalled item lost")
    `HCBP_ASSERT_NEXT(a_burst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "byte burst broken")
    `HCBP_ASSERT(a_adv_free, s1_st.adv |-> !m_axis_tvalid || m_axis_tlast, "item merged over unfinished bytes")

endmodule
